// ===== rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the stack bytecode sequencer.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned INDEX_BITS_DEF  = 16;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned IMM_W      = 5;
  localparam int unsigned BYTE_W     = OP_W + IMM_W;
  localparam int unsigned TBL_IDX_W  = 16;
  localparam int unsigned ARITY_W    = 16;
  localparam int unsigned SLOT_W     = 9;
  localparam int unsigned SHORT_BIT  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_IMM   = 3'd0,
    OP_CONST = 3'd1,
    OP_VAR   = 3'd2,
    OP_ARITY = 3'd3,
    OP_FUNC2 = 3'd4,
    OP_FUNC  = 3'd5,
    OP_STORE = 3'd6,
    OP_RSVD  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_CONST = 3'd1,
    CMD_VAR   = 3'd2,
    CMD_CALL  = 3'd3,
    CMD_STORE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_EMPTY = 3'd2,
    ST_EXTRA = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                 command;
    logic [TBL_IDX_W-1:0] table_index;
    logic [ARITY_W-1:0]   call_arity;
    logic [SLOT_W-1:0]    stack_slot;
    status_e              status;
    logic                 program_end;
  } res_t;

endpackage

// ===== rtl/sbs_if.sv =====
// ----------------------------------------------------------------------------
// sbs_if
// Valid/ready channels: bytecode input and decoded command output.
// ----------------------------------------------------------------------------
interface sbs_in_if
  import sbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              last_byte;

  modport source (output valid, code_byte, last_byte, input ready);
  modport sink   (input valid, code_byte, last_byte, output ready);
endinterface

interface sbs_out_if
  import sbs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  cmd_e                 command;
  logic [TBL_IDX_W-1:0] table_index;
  logic [ARITY_W-1:0]   call_arity;
  logic [SLOT_W-1:0]    stack_slot;
  status_e              status;
  logic                 program_end;

  modport source (output valid, command, table_index, call_arity, stack_slot, status,
                  program_end, input ready);
  modport sink   (input valid, command, table_index, call_arity, stack_slot, status,
                  program_end, output ready);
endinterface

// ===== rtl/sbs_step.sv =====
// ----------------------------------------------------------------------------
// sbs_step
// Sequencer state (accumulator, arity, depth, halt) and one-byte decode.
// ----------------------------------------------------------------------------
module sbs_step
  import sbs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] code_byte_i,
  input  logic              last_byte_i,
  output res_t              res_o
);

  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW      = ((DEPTH_W > ARITY_W) ? DEPTH_W : ARITY_W) + 1;

  logic [INDEX_BITS-1:0] acc_q, acc_d;
  logic [ARITY_W-1:0]    arity_q, arity_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic                  halted_q, halted_d;
  status_e               cause_q, cause_d;
  logic                  after_ar_q, after_ar_d;

  op_e                        op;
  logic [INDEX_BITS-1:0]      acc_new;
  logic [INDEX_BITS-1:0]      acc_call;
  logic [INDEX_BITS+IMM_W-1:0] acc_shift;
  logic [INDEX_BITS+TBL_IDX_W-1:0] idx_ext, idx_call_ext;
  logic [TBL_IDX_W-1:0]       idx16, idx16_call;
  logic                       short_call;
  logic [ARITY_W-1:0]         n;
  logic [CW-1:0]              depth_c, n_c, diff;
  res_t                       res;

  always_comb begin
    op         = op_e'(code_byte_i[BYTE_W-1 -: OP_W]);
    acc_shift  = {acc_q, code_byte_i[IMM_W-1:0]};
    acc_new    = acc_shift[INDEX_BITS-1:0];
    short_call = (arity_q == '0) && ((op == OP_FUNC2) || after_ar_q);
    acc_call   = acc_new;
    if (short_call) begin
      acc_call[SHORT_BIT] = 1'b0;
    end
    idx_ext      = {{TBL_IDX_W{1'b0}}, acc_new};
    idx_call_ext = {{TBL_IDX_W{1'b0}}, acc_call};
    idx16        = idx_ext[TBL_IDX_W-1:0];
    idx16_call   = idx_call_ext[TBL_IDX_W-1:0];
    n = arity_q;
    if (short_call) begin
      n = acc_new[SHORT_BIT] ? ARITY_W'(2) : ARITY_W'(1);
    end
    depth_c = CW'(depth_q);
    n_c     = CW'(n);
    diff    = depth_c - n_c;

    res             = '0;
    res.command     = CMD_NONE;
    res.status      = ST_OK;
    res.program_end = last_byte_i;

    acc_d      = acc_q;
    arity_d    = arity_q;
    depth_d    = depth_q;
    halted_d   = halted_q;
    cause_d    = cause_q;
    after_ar_d = after_ar_q;

    if (!halted_q) begin
      acc_d      = acc_new;
      after_ar_d = 1'b0;
      case (op)
        OP_CONST, OP_VAR: begin
          if (depth_c >= CW'(STACK_DEPTH)) begin
            res.status = ST_OVER;
          end else begin
            res.command     = (op == OP_CONST) ? CMD_CONST : CMD_VAR;
            res.table_index = idx16;
            res.stack_slot  = SLOT_W'(depth_c);
            depth_d         = depth_q + DEPTH_W'(1);
          end
          acc_d = '0;
        end
        OP_ARITY: begin
          arity_d    = idx16;
          after_ar_d = 1'b1;
          acc_d      = '0;
        end
        OP_FUNC2, OP_FUNC: begin
          if (n_c > depth_c) begin
            res.status = ST_UNDER;
          end else if (diff >= CW'(STACK_DEPTH)) begin
            res.status = ST_OVER;
          end else begin
            res.command     = CMD_CALL;
            res.table_index = idx16_call;
            res.call_arity  = n;
            res.stack_slot  = SLOT_W'(diff);
            depth_d         = DEPTH_W'(diff + CW'(1));
          end
          arity_d = '0;
          acc_d   = '0;
        end
        OP_STORE: begin
          if (depth_q == '0) begin
            res.status = ST_UNDER;
          end else begin
            res.command     = CMD_STORE;
            res.table_index = idx16;
            res.stack_slot  = SLOT_W'(depth_c - CW'(1));
            depth_d         = depth_q - DEPTH_W'(1);
          end
          acc_d = '0;
        end
        default: ;
      endcase

      if (res.status != ST_OK) begin
        halted_d = 1'b1;
        cause_d  = res.status;
      end else if (last_byte_i) begin
        if (depth_d == '0) begin
          res.status = ST_EMPTY;
        end else if (depth_d > DEPTH_W'(1)) begin
          res.status = ST_EXTRA;
        end
      end
    end else if (last_byte_i) begin
      res.status = cause_q;
    end

    if (last_byte_i) begin
      acc_d      = '0;
      arity_d    = '0;
      depth_d    = '0;
      halted_d   = 1'b0;
      cause_d    = ST_OK;
      after_ar_d = 1'b0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      arity_q    <= '0;
      depth_q    <= '0;
      halted_q   <= 1'b0;
      cause_q    <= ST_OK;
      after_ar_q <= 1'b0;
    end else if (fire_i) begin
      acc_q      <= acc_d;
      arity_q    <= arity_d;
      depth_q    <= depth_d;
      halted_q   <= halted_d;
      cause_q    <= cause_d;
      after_ar_q <= after_ar_d;
    end
  end

endmodule

// ===== rtl/sbs_out_reg.sv =====
// ----------------------------------------------------------------------------
// sbs_out_reg
// Result register; takes a new result while empty or as the held one leaves.
// ----------------------------------------------------------------------------
module sbs_out_reg
  import sbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  sbs_out_if.source out_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.command     = res_q.command;
  assign out_o.table_index = res_q.table_index;
  assign out_o.call_arity  = res_q.call_arity;
  assign out_o.stack_slot  = res_q.stack_slot;
  assign out_o.status      = res_q.status;
  assign out_o.program_end = res_q.program_end;

endmodule

// ===== rtl/stack_bytecode_sequencer.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_sequencer
// Decodes a bytecode stream into stack commands and tracks stack depth.
//
//   channel | dir | payload                                            | transfer
//   in_i    | in  | code_byte, last_byte                               | valid&ready
//   out_o   | out | command, table_index, call_arity, stack_slot,      | valid&ready
//           |     | status, program_end                                |
//
// One byte per cycle while in_i.ready; its result is on out_o in the cycle after.
// in_i.ready is high while the result register is empty or being drained.
// Reset clears the accumulator, arity, depth and halt state; a last byte
// clears them again after its result is formed.
// ----------------------------------------------------------------------------
module stack_bytecode_sequencer
  import sbs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbs_in_if.sink    in_i,
  sbs_out_if.source out_o
);

  logic fire;
  logic free;
  res_t res;

  assign in_i.ready = free;
  assign fire       = in_i.valid && free;

  sbs_step #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .code_byte_i (in_i.code_byte),
    .last_byte_i (in_i.last_byte),
    .res_o       (res)
  );

  sbs_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// ===== tb/sbs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbs_checker
// Watches both channels of the stack bytecode sequencer, decodes every
// accepted byte into the command it must produce, and compares each output
// transfer field by field with the oldest command still due.
// ----------------------------------------------------------------------------
module sbs_checker
  import sbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sbs_in_if    in_ch,
  sbs_out_if   out_ch,
  output int   fail_cnt,
  output int   due_cnt,
  output int   byte_cnt,
  output int   prog_cnt,
  output int   halt_cnt,
  output int   call_cnt
);

  localparam int DEPTH_MAX = STACK_DEPTH_DEF;

  logic [TBL_IDX_W-1:0] acc_r;
  logic [ARITY_W-1:0]   arity_r;
  int                   depth_r;
  bit                   halted_r;
  status_e              cause_r;
  bit                   arity_prev_r;

  res_t cmd_due_q[$];

  initial begin
    acc_r        = '0;
    arity_r      = '0;
    depth_r      = 0;
    halted_r     = 1'b0;
    cause_r      = ST_OK;
    arity_prev_r = 1'b0;
  end

  function automatic res_t decode_byte(input logic [BYTE_W-1:0] code, input logic is_last);
    res_t                 r;
    op_e                  op;
    logic [TBL_IDX_W-1:0] nxt;
    int                   n;
    bit                   prev_arity;
    r.command     = CMD_NONE;
    r.table_index = '0;
    r.call_arity  = '0;
    r.stack_slot  = '0;
    r.status      = ST_OK;
    r.program_end = is_last;
    op = op_e'(code[BYTE_W-1:IMM_W]);
    if (!halted_r) begin
      nxt          = {acc_r[TBL_IDX_W-IMM_W-1:0], code[IMM_W-1:0]};
      prev_arity   = arity_prev_r;
      arity_prev_r = 1'b0;
      case (op)
        OP_CONST, OP_VAR: begin
          if (depth_r >= DEPTH_MAX) begin
            r.status = ST_OVER;
          end else begin
            r.command     = (op == OP_CONST) ? CMD_CONST : CMD_VAR;
            r.table_index = nxt;
            r.stack_slot  = SLOT_W'(depth_r);
            depth_r++;
          end
          nxt = '0;
        end
        OP_ARITY: begin
          arity_r      = nxt;
          arity_prev_r = 1'b1;
          nxt          = '0;
        end
        OP_FUNC2, OP_FUNC: begin
          n = arity_r;
          // short form: bit 4 of the index selects two arguments
          if (n == 0 && (op == OP_FUNC2 || prev_arity)) begin
            n = nxt[SHORT_BIT] ? 2 : 1;
            nxt[SHORT_BIT] = 1'b0;
          end
          if (n > depth_r) begin
            r.status = ST_UNDER;
          end else if (depth_r - n >= DEPTH_MAX) begin
            r.status = ST_OVER;
          end else begin
            r.command     = CMD_CALL;
            r.table_index = nxt;
            r.call_arity  = ARITY_W'(n);
            r.stack_slot  = SLOT_W'(depth_r - n);
            depth_r       = depth_r - n + 1;
          end
          arity_r = '0;
          nxt     = '0;
        end
        OP_STORE: begin
          if (depth_r == 0) begin
            r.status = ST_UNDER;
          end else begin
            depth_r--;
            r.command     = CMD_STORE;
            r.table_index = nxt;
            r.stack_slot  = SLOT_W'(depth_r);
          end
          nxt = '0;
        end
        default: ;
      endcase
      acc_r = nxt;
      if (r.status != ST_OK) begin
        halted_r = 1'b1;
        cause_r  = r.status;
      end else if (is_last) begin
        if (depth_r == 0) r.status = ST_EMPTY;
        else if (depth_r > 1) r.status = ST_EXTRA;
      end
    end else if (is_last) begin
      r.status = cause_r;
    end
    if (is_last) begin
      acc_r        = '0;
      arity_r      = '0;
      depth_r      = 0;
      halted_r     = 1'b0;
      cause_r      = ST_OK;
      arity_prev_r = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_due_q.size() == 0) begin
          $error("result transfer with nothing due: command %0d status %0d",
                 out_ch.command, out_ch.status);
          fail_cnt++;
        end else begin
          want = cmd_due_q.pop_front();
          check_field("command", 16'(want.command), 16'(out_ch.command));
          check_field("table_index", want.table_index, out_ch.table_index);
          check_field("call_arity", want.call_arity, out_ch.call_arity);
          check_field("stack_slot", 16'(want.stack_slot), 16'(out_ch.stack_slot));
          check_field("status", 16'(want.status), 16'(out_ch.status));
          check_field("program_end", 16'(want.program_end), 16'(out_ch.program_end));
          if (want.program_end) begin
            prog_cnt++;
            if (want.status == ST_UNDER || want.status == ST_OVER) halt_cnt++;
          end
          if (want.command == CMD_CALL) call_cnt++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_due_q.push_back(decode_byte(in_ch.code_byte, in_ch.last_byte));
        byte_cnt++;
      end
      due_cnt = cmd_due_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives bytecode programs into the stack bytecode sequencer: a directed
// set of corner programs, full-stack programs, then random programs that
// are mostly well formed, with random gaps on both sides, a long output
// hold-off and drain pauses. Checking is done by sbs_checker.
// ----------------------------------------------------------------------------
module tb;
  import sbs_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RAND_BYTES   = 300;
  localparam int DEPTH_MAX_TB = STACK_DEPTH_DEF;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  bit   hold_req;
  int   n_sent;
  int   stall_cycles;

  int fail_cnt, due_cnt, byte_cnt, prog_cnt, halt_cnt, call_cnt;

  sbs_in_if  in_ch ();
  sbs_out_if out_ch ();

  stack_bytecode_sequencer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  sbs_checker chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .fail_cnt(fail_cnt),
    .due_cnt (due_cnt),
    .byte_cnt(byte_cnt),
    .prog_cnt(prog_cnt),
    .halt_cnt(halt_cnt),
    .call_cnt(call_cnt)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: per-transfer stall, plus a long hold-off on request
  initial begin : sink_proc
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] code, input logic is_last);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_byte <= code;
    in_ch.last_byte <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_prefix(input int cnt);
    repeat (cnt) send_byte({OP_IMM, IMM_W'($urandom)}, 1'b0);
  endtask

  // op byte carrying a value wider than one immediate, high chunks first
  task automatic send_value_op(input op_e op, input int v, input logic is_last);
    if (v > 16'h7FFF) send_byte({OP_IMM, IMM_W'(v >> 15)}, 1'b0);
    if (v > 16'h03FF) send_byte({OP_IMM, IMM_W'(v >> 10)}, 1'b0);
    if (v > 16'h001F) send_byte({OP_IMM, IMM_W'(v >> 5)}, 1'b0);
    send_byte({op, IMM_W'(v)}, is_last);
  endtask

  task automatic random_program(input int ops, input bit broken);
    int               d;
    int               k;
    int               n;
    int               a;
    int               pre;
    int               pick;
    int               fault_at;
    op_e              op;
    logic [IMM_W-1:0] imm;
    d        = 0;
    fault_at = (broken && ops > 0) ? $urandom_range(0, ops - 1) : -1;
    for (k = 0; k < ops; k++) begin
      pick = $urandom_range(0, 99);
      pre  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      imm  = IMM_W'($urandom);
      if (k == fault_at) begin
        if (pick < 50) begin
          send_value_op(OP_ARITY, $urandom_range(d + 1, 65535), 1'b0);
          send_byte({OP_FUNC, imm}, 1'b0);
        end else begin
          repeat (d + 1) send_byte({OP_STORE, imm}, 1'b0);
        end
        d = 0;
      end else if (pick < 5) begin
        send_byte(BYTE_W'($urandom), 1'b0);
      end else if (pick < 35 || d <= 0) begin
        send_prefix(pre);
        send_byte({pick[0] ? OP_CONST : OP_VAR, imm}, 1'b0);
        d++;
      end else if (pick < 50) begin
        n = (d >= 2 && $urandom_range(0, 1) == 1) ? 2 : 1;
        imm[SHORT_BIT] = (n == 2);
        send_prefix(pre);
        send_byte({OP_FUNC2, imm}, 1'b0);
        d = d - n + 1;
      end else if (pick < 65) begin
        a  = $urandom_range(0, (d < 31) ? d : 31);
        op = pick[0] ? OP_FUNC : OP_FUNC2;
        send_value_op(OP_ARITY, a, 1'b0);
        if (a != 0) begin
          send_prefix(pre);
          n = a;
        end else begin
          n = (d >= 2 && $urandom_range(0, 1) == 1) ? 2 : 1;
          imm[SHORT_BIT] = (n == 2);
        end
        send_byte({op, imm}, 1'b0);
        d = d - n + 1;
      end else if (pick < 72) begin
        send_prefix(pre);
        send_byte({OP_FUNC, imm}, 1'b0);
        d++;
      end else if (pick < 90) begin
        send_prefix(pre);
        send_byte({OP_STORE, imm}, 1'b0);
        d--;
      end else begin
        send_byte({pick[0] ? OP_RSVD : OP_IMM, imm}, 1'b0);
      end
    end
    imm = IMM_W'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      if (d <= 0) begin
        send_byte({OP_CONST, imm}, 1'b1);
      end else if (d == 1) begin
        send_byte({OP_IMM, imm}, 1'b1);
      end else if (d == 2) begin
        imm[SHORT_BIT] = 1'b1;
        send_byte({OP_FUNC2, imm}, 1'b1);
      end else begin
        send_value_op(OP_ARITY, d, 1'b0);
        send_byte({OP_FUNC, imm}, 1'b1);
      end
    end else begin
      send_byte(BYTE_W'($urandom), 1'b1);
    end
  endtask

  initial begin : stimulus
    int k;
    int rand_goal;
    int prog_no;
    int ops;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.code_byte = '0;
    in_ch.last_byte = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    n_sent          = 0;
    stall_cycles    = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // wide index, short calls both ways, arity forms, store, clean end
    send_byte({OP_IMM, 5'h1F}, 1'b0);
    send_byte({OP_IMM, 5'h1F}, 1'b0);
    send_byte({OP_IMM, 5'h1F}, 1'b0);
    send_byte({OP_CONST, 5'h1F}, 1'b0);
    send_byte({OP_VAR, 5'h00}, 1'b0);
    send_byte({OP_RSVD, 5'h05}, 1'b0);
    send_byte({OP_FUNC2, 5'h13}, 1'b0);
    send_byte({OP_CONST, 5'h01}, 1'b0);
    send_byte({OP_ARITY, 5'h00}, 1'b0);
    send_byte({OP_FUNC, 5'h12}, 1'b0);
    send_byte({OP_CONST, 5'h02}, 1'b0);
    send_byte({OP_ARITY, 5'h02}, 1'b0);
    send_byte({OP_FUNC2, 5'h1F}, 1'b0);
    send_byte({OP_FUNC, 5'h03}, 1'b0);
    send_byte({OP_STORE, 5'h04}, 1'b1);
    // store underflow, halted bytes
    send_byte({OP_STORE, 5'h00}, 1'b0);
    send_byte({OP_IMM, 5'h09}, 1'b0);
    send_byte({OP_CONST, 5'h01}, 1'b1);
    // empty stack at end
    send_byte({OP_IMM, 5'h00}, 1'b1);
    // extra values at end
    send_byte({OP_CONST, 5'h01}, 1'b0);
    send_byte({OP_CONST, 5'h02}, 1'b0);
    send_byte({OP_FUNC, 5'h00}, 1'b1);
    // call underflow on the last byte
    send_byte({OP_CONST, 5'h01}, 1'b0);
    send_byte({OP_FUNC2, 5'h10}, 1'b1);

    // full stack: push overflow, call overflow, call taking the whole stack
    for (k = 0; k < 3; k++) begin
      repeat (DEPTH_MAX_TB) send_byte({(k == 1) ? OP_VAR : OP_CONST, IMM_W'($urandom)}, 1'b0);
      case (k)
        0: begin
          send_byte({OP_CONST, IMM_W'($urandom)}, 1'b0);
          send_byte({OP_VAR, IMM_W'($urandom)}, 1'b1);
        end
        1: begin
          send_byte({OP_FUNC, IMM_W'($urandom)}, 1'b0);
          send_byte({OP_STORE, IMM_W'($urandom)}, 1'b1);
        end
        default: begin
          send_value_op(OP_ARITY, DEPTH_MAX_TB, 1'b0);
          send_byte({OP_FUNC, IMM_W'($urandom)}, 1'b1);
        end
      endcase
    end

    rand_goal = n_sent + RAND_BYTES;
    prog_no   = 0;
    while (n_sent < rand_goal) begin
      prog_no++;
      idle_on = ($urandom_range(0, 4) != 0);
      ops     = $urandom_range(0, 14);
      if (prog_no % 12 == 0) begin
        in_ch.valid <= 1'b0;
        while (due_cnt != 0) @(negedge clk_i);
      end
      if (prog_no % 15 == 7) begin
        hold_req = 1'b1;
        idle_on  = 1'b0;
        ops      = 24;
      end
      random_program(ops, $urandom_range(0, 9) == 0);
    end
    in_ch.valid <= 1'b0;

    while (due_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("covered %0d bytes in %0d programs: %0d calls, %0d halted on stack faults,",
             byte_cnt, prog_cnt, call_cnt, halt_cnt);
    $display("with full-stack programs, random gaps, output hold-offs and drain pauses");
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
